/* sv/tfg_pkg.sv */
// Shared types, constants and helpers for the triangle frame geometry block.
package tfg_pkg;

	localparam int unsigned COMP_W = 32;
	localparam int unsigned CSUM_W = 34;
	localparam int unsigned AREA_W = 31;
	localparam int unsigned IN_TDATA_W = 288;
	localparam int unsigned OUT_TDATA_W = 136;

	localparam logic [63:0] ONE_Q24 = 64'h0000_0000_0100_0000;

	// last count value of each working phase of the back end
	localparam logic [5:0] CROSS_LAST = 6'd6;
	localparam logic [5:0] SQN_LAST = 6'd9;
	localparam logic [5:0] SQRT_LAST = 6'd63;
	localparam logic [5:0] DIV_LAST = 6'd25;
	localparam logic [5:0] SQE_LAST = 6'd3;
	localparam logic [5:0] EX_LAST = 6'd6;

	// ceil(2^34 / 3) less its 2^32 term, which is added as a shift
	localparam logic [30:0] RECIP3_LO = 31'h5555_5556;

	localparam logic [2:0] K_EDGE12 = 3'd0;
	localparam logic [2:0] K_EDGE13 = 3'd1;
	localparam logic [2:0] K_NORMAL = 3'd2;
	localparam logic [2:0] K_EY = 3'd3;
	localparam logic [2:0] K_EX = 3'd4;
	localparam logic [2:0] K_CENTROID = 3'd5;

	typedef logic [2:0][31:0] vec3_t;
	typedef logic [2:0][33:0] sum3_t;

	typedef struct packed {
		vec3_t e12;
		vec3_t e13;
		sum3_t csum;
	} item_t;

	typedef struct packed {
		vec3_t e12;
		vec3_t e13;
		vec3_t nn;
		vec3_t ey;
		vec3_t ex;
		vec3_t ce;
		logic [30:0] area;
		logic zarea;
		logic zedge;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CROSS,
		B_SQN,
		B_SQRTN,
		B_DIVN,
		B_SQE,
		B_SQRTE,
		B_DIVE,
		B_EX,
		B_DONE
	} bstate_t;

	typedef enum logic [2:0] {
		T_NONE,
		T_SET,
		T_SUB,
		T_ACC0,
		T_ACC33,
		T_ACC64
	} tag_op_t;

	typedef struct packed {
		tag_op_t op;
		logic [1:0] idx;
	} tag_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		logic signed [63:0] s;
		begin
			s = $signed(v);
			if (s > 64'sh0000_0000_7FFF_FFFF)
				sat32 = 32'h7FFF_FFFF;
			else if (s < 64'shFFFF_FFFF_8000_0000)
				sat32 = 32'h8000_0000;
			else
				sat32 = v[31:0];
		end
	endfunction

endpackage

/* sv/tfg_front.sv */
// Front end: takes a triangle, forms saturated edges and vertex sums.
module tfg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [287:0]         s_tdata,
	output logic                 item_valid,
	output tfg_pkg::item_t       item,
	input  logic                 item_ready
);

	logic            valid_s1;
	tfg_pkg::item_t  item_s1;
	tfg_pkg::item_t  item_d;

	always_comb begin
		logic [63:0] v1, v2, v3;
		item_d = '0;
		for (int c = 0; c < 3; c++) begin
			v1 = {{32{s_tdata[c*32+31]}}, s_tdata[c*32 +: 32]};
			v2 = {{32{s_tdata[96+c*32+31]}}, s_tdata[96+c*32 +: 32]};
			v3 = {{32{s_tdata[192+c*32+31]}}, s_tdata[192+c*32 +: 32]};
			item_d.e12[c] = tfg_pkg::sat32(v2 - v1);
			item_d.e13[c] = tfg_pkg::sat32(v3 - v1);
			item_d.csum[c] = v1[33:0] + v2[33:0] + v3[33:0];
		end
	end

	assign s_tready = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* sv/tfg_queue.sv */
// Two-entry queue between front and back end.
module tfg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tfg_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output tfg_pkg::item_t  out_item
);

	tfg_pkg::item_t  mem_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

endmodule

/* sv/tfg_back.sv */
// Back end: cross product, square roots, normalising divides and centroid.
module tfg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tfg_pkg::item_t  in_item,
	output logic            res_valid,
	input  logic            res_ready,
	output tfg_pkg::res_t   res
);

	tfg_pkg::bstate_t state_q, state_d;
	logic [5:0]       cnt_q;

	tfg_pkg::vec3_t   e12_q, e13_q, nn_q, ey_q;
	logic [2:0][63:0] nc_q;
	logic [127:0]     acc_q;
	logic [65:0]      srem_q;
	logic [63:0]      sroot_q;
	logic [2:0][63:0] lr_q;
	logic [2:0][24:0] lq_q;
	logic [30:0]      area_q;
	logic             zarea_q;
	logic             zedge_q;

	logic [2:0][32:0] cm_q;
	logic [2:0][31:0] cquo_q;
	logic [2:0]       cneg_q;
	logic             cdone_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] p_s1;
	tfg_pkg::tag_t      tag_d, tag_s1;

	logic             take;
	logic             enter;
	logic             is_div;
	logic             is_sqrt;
	logic [63:0]      den;
	logic [2:0][63:0] num;

	assign in_ready = (state_q == tfg_pkg::B_IDLE);
	assign res_valid = (state_q == tfg_pkg::B_DONE);
	assign take = in_valid && in_ready;
	assign enter = (state_d != state_q);
	assign is_div = (state_q == tfg_pkg::B_DIVN) || (state_q == tfg_pkg::B_DIVE);
	assign is_sqrt = (state_q == tfg_pkg::B_SQRTN) || (state_q == tfg_pkg::B_SQRTE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tfg_pkg::B_IDLE:  if (in_valid) state_d = tfg_pkg::B_CROSS;
			tfg_pkg::B_CROSS: if (cnt_q == tfg_pkg::CROSS_LAST) state_d = tfg_pkg::B_SQN;
			tfg_pkg::B_SQN:   if (cnt_q == tfg_pkg::SQN_LAST) state_d = tfg_pkg::B_SQRTN;
			tfg_pkg::B_SQRTN: if (cnt_q == tfg_pkg::SQRT_LAST) state_d = tfg_pkg::B_DIVN;
			tfg_pkg::B_DIVN:  if (cnt_q == tfg_pkg::DIV_LAST) state_d = tfg_pkg::B_SQE;
			tfg_pkg::B_SQE:   if (cnt_q == tfg_pkg::SQE_LAST) state_d = tfg_pkg::B_SQRTE;
			tfg_pkg::B_SQRTE: if (cnt_q == tfg_pkg::SQRT_LAST) state_d = tfg_pkg::B_DIVE;
			tfg_pkg::B_DIVE:  if (cnt_q == tfg_pkg::DIV_LAST) state_d = tfg_pkg::B_EX;
			tfg_pkg::B_EX:    if (cnt_q == tfg_pkg::EX_LAST) state_d = tfg_pkg::B_DONE;
			tfg_pkg::B_DONE:  if (res_ready) state_d = tfg_pkg::B_IDLE;
			default:          state_d = tfg_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfg_pkg::B_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (enter)
				cnt_q <= '0;
			else if (state_q != tfg_pkg::B_IDLE && state_q != tfg_pkg::B_DONE)
				cnt_q <= cnt_q + 6'd1;
		end
	end

	// multiplier operand and write-back tag selection
	always_comb begin
		tfg_pkg::vec3_t va, vb;
		logic [63:0] m;
		logic [1:0]  ci;
		logic [1:0]  part;
		ma = '0;
		mb = '0;
		tag_d = '{op: tfg_pkg::T_NONE, idx: 2'd0};
		va = (state_q == tfg_pkg::B_EX) ? ey_q : e12_q;
		vb = (state_q == tfg_pkg::B_EX) ? nn_q : e13_q;
		ci = 2'd0;
		part = 2'd0;
		m = '0;
		if ((state_q == tfg_pkg::B_CROSS || state_q == tfg_pkg::B_EX) && cnt_q < 6'd6) begin
			case (cnt_q[2:0])
				3'd0: begin
					ma = $signed({va[1][31], va[1]}); mb = $signed({vb[2][31], vb[2]});
					tag_d = '{op: tfg_pkg::T_SET, idx: 2'd0};
				end
				3'd1: begin
					ma = $signed({vb[1][31], vb[1]}); mb = $signed({va[2][31], va[2]});
					tag_d = '{op: tfg_pkg::T_SUB, idx: 2'd0};
				end
				3'd2: begin
					ma = $signed({vb[0][31], vb[0]}); mb = $signed({va[2][31], va[2]});
					tag_d = '{op: tfg_pkg::T_SET, idx: 2'd1};
				end
				3'd3: begin
					ma = $signed({va[0][31], va[0]}); mb = $signed({vb[2][31], vb[2]});
					tag_d = '{op: tfg_pkg::T_SUB, idx: 2'd1};
				end
				3'd4: begin
					ma = $signed({va[0][31], va[0]}); mb = $signed({vb[1][31], vb[1]});
					tag_d = '{op: tfg_pkg::T_SET, idx: 2'd2};
				end
				3'd5: begin
					ma = $signed({vb[0][31], vb[0]}); mb = $signed({va[1][31], va[1]});
					tag_d = '{op: tfg_pkg::T_SUB, idx: 2'd2};
				end
				default: begin
					ma = '0; mb = '0;
				end
			endcase
		end else if (state_q == tfg_pkg::B_SQN && cnt_q < 6'd9) begin
			case (cnt_q[3:0])
				4'd0: begin ci = 2'd0; part = 2'd0; end
				4'd1: begin ci = 2'd0; part = 2'd1; end
				4'd2: begin ci = 2'd0; part = 2'd2; end
				4'd3: begin ci = 2'd1; part = 2'd0; end
				4'd4: begin ci = 2'd1; part = 2'd1; end
				4'd5: begin ci = 2'd1; part = 2'd2; end
				4'd6: begin ci = 2'd2; part = 2'd0; end
				4'd7: begin ci = 2'd2; part = 2'd1; end
				4'd8: begin ci = 2'd2; part = 2'd2; end
				default: begin ci = 2'd0; part = 2'd0; end
			endcase
			m = nc_q[ci][63] ? (64'd0 - nc_q[ci]) : nc_q[ci];
			case (part)
				2'd0: begin
					ma = $signed({1'b0, m[31:0]}); mb = $signed({1'b0, m[31:0]});
					tag_d = '{op: tfg_pkg::T_ACC0, idx: ci};
				end
				2'd1: begin
					ma = $signed({1'b0, m[31:0]}); mb = $signed({1'b0, m[63:32]});
					tag_d = '{op: tfg_pkg::T_ACC33, idx: ci};
				end
				default: begin
					ma = $signed({1'b0, m[63:32]}); mb = $signed({1'b0, m[63:32]});
					tag_d = '{op: tfg_pkg::T_ACC64, idx: ci};
				end
			endcase
		end else if (state_q == tfg_pkg::B_SQE && cnt_q < 6'd3) begin
			ci = cnt_q[1:0];
			m = {32'd0, e13_q[ci][31] ? (32'd0 - e13_q[ci]) : e13_q[ci]};
			ma = $signed({1'b0, m[31:0]});
			mb = $signed({1'b0, m[31:0]});
			tag_d = '{op: tfg_pkg::T_ACC0, idx: ci};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s1 <= '{op: tfg_pkg::T_NONE, idx: 2'd0};
		else
			tag_s1 <= tag_d;
	end

	always_ff @(posedge clk) begin
		p_s1 <= ma * mb;
	end

	// divider lane inputs; a zero edge length divides by one
	always_comb begin
		den = sroot_q;
		if (state_q == tfg_pkg::B_DIVE && sroot_q == 64'd0)
			den = tfg_pkg::ONE_Q24;
		for (int i = 0; i < 3; i++) begin
			if (state_q == tfg_pkg::B_DIVN)
				num[i] = nc_q[i][63] ? (64'd0 - nc_q[i]) : nc_q[i];
			else
				num[i] = {32'd0, e13_q[i][31] ? (32'd0 - e13_q[i]) : e13_q[i]};
		end
	end

	always_ff @(posedge clk) begin
		logic [67:0] rnext, trial;
		logic [64:0] r2;
		logic [31:0] qv;
		logic [33:0] cmag;
		logic [63:0] lp;
		logic [65:0] full;
		if (take) begin
			e12_q <= in_item.e12;
			e13_q <= in_item.e13;
		end

		// product write-back
		case (tag_s1.op)
			tfg_pkg::T_SET: nc_q[tag_s1.idx] <= p_s1[63:0];
			tfg_pkg::T_SUB: nc_q[tag_s1.idx] <= nc_q[tag_s1.idx] - p_s1[63:0];
			default: ;
		endcase

		if (enter && (state_d == tfg_pkg::B_SQN || state_d == tfg_pkg::B_SQE)) begin
			acc_q <= '0;
		end else if (is_sqrt) begin
			acc_q <= {acc_q[125:0], 2'b00};
		end else begin
			case (tag_s1.op)
				tfg_pkg::T_ACC0:  acc_q <= acc_q + {64'd0, p_s1[63:0]};
				tfg_pkg::T_ACC33: acc_q <= acc_q + {31'd0, p_s1[63:0], 33'd0};
				tfg_pkg::T_ACC64: acc_q <= acc_q + {p_s1[63:0], 64'd0};
				default: ;
			endcase
		end

		// restoring square root, one result bit a cycle
		if (enter && (state_d == tfg_pkg::B_SQRTN || state_d == tfg_pkg::B_SQRTE)) begin
			srem_q <= '0;
			sroot_q <= '0;
		end else if (is_sqrt) begin
			rnext = {srem_q, acc_q[127:126]};
			trial = {2'b00, sroot_q, 2'b01};
			if (rnext >= trial) begin
				rnext = rnext - trial;
				sroot_q <= {sroot_q[62:0], 1'b1};
			end else begin
				sroot_q <= {sroot_q[62:0], 1'b0};
			end
			srem_q <= rnext[65:0];
		end

		// three fraction divider lanes
		if (is_div) begin
			if (cnt_q == 6'd0) begin
				if (state_q == tfg_pkg::B_DIVN) begin
					zarea_q <= (sroot_q == 64'd0);
					area_q <= (sroot_q[63:56] != 8'd0) ? {31{1'b1}} : sroot_q[55:25];
				end else begin
					zedge_q <= (sroot_q == 64'd0);
				end
				for (int i = 0; i < 3; i++) begin
					if (num[i] >= den) begin
						lq_q[i] <= 25'd1;
						lr_q[i] <= num[i] - den;
					end else begin
						lq_q[i] <= 25'd0;
						lr_q[i] <= num[i];
					end
				end
			end else if (cnt_q == tfg_pkg::DIV_LAST) begin
				for (int i = 0; i < 3; i++) begin
					qv = {7'd0, lq_q[i]};
					if (state_q == tfg_pkg::B_DIVN)
						nn_q[i] <= zarea_q ? 32'd0 : (nc_q[i][63] ? (32'd0 - qv) : qv);
					else
						ey_q[i] <= e13_q[i][31] ? (32'd0 - qv) : qv;
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					r2 = {lr_q[i], 1'b0};
					if (r2 >= {1'b0, den}) begin
						r2 = r2 - {1'b0, den};
						lq_q[i] <= {lq_q[i][23:0], 1'b1};
					end else begin
						lq_q[i] <= {lq_q[i][23:0], 1'b0};
					end
					lr_q[i] <= r2[63:0];
				end
			end
		end

		// centroid: magnitude of each vertex sum times the reciprocal of three,
		// exact for sums below 2^33
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				cneg_q[i] <= in_item.csum[i][33];
				cmag = in_item.csum[i][33] ? (34'd0 - in_item.csum[i]) : in_item.csum[i];
				cm_q[i] <= cmag[32:0];
			end
		end
		for (int i = 0; i < 3; i++) begin
			lp = cm_q[i] * tfg_pkg::RECIP3_LO;
			full = {1'b0, cm_q[i], 32'd0} + {2'd0, lp};
			cquo_q[i] <= full[65:34];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cdone_q <= 1'b1;
		else
			cdone_q <= !take;
	end

	always_comb begin
		logic [63:0] mag;
		logic [63:0] cq;
		res.e12 = e12_q;
		res.e13 = e13_q;
		res.nn = nn_q;
		res.ey = ey_q;
		res.area = area_q;
		res.zarea = zarea_q;
		res.zedge = zedge_q;
		for (int i = 0; i < 3; i++) begin
			// ex was accumulated into the cross registers, truncate toward zero
			mag = nc_q[i][63] ? (64'd0 - nc_q[i]) : nc_q[i];
			mag = {24'd0, mag[63:24]};
			res.ex[i] = tfg_pkg::sat32(nc_q[i][63] ? (64'd0 - mag) : mag);
			cq = {32'd0, cquo_q[i]};
			res.ce[i] = tfg_pkg::sat32(cneg_q[i] ? (64'd0 - cq) : cq);
		end
	end

	a_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && zarea_q) |-> (area_q == 31'd0))
		else $error("zero area flagged with nonzero area");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(is_div && cnt_q != 6'd0 && den != 64'd0) |->
		(lr_q[0] < den && lr_q[1] < den && lr_q[2] < den))
		else $error("divider remainder out of range");

	a_centroid_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cdone_q)
		else $error("results handed on before centroid quotient settled");

	a_root_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		is_sqrt |-> (tag_s1.op == tfg_pkg::T_NONE))
		else $error("product write-back during square root");

endmodule

/* sv/tfg_emit.sv */
// Result sequencer: six result transfers per triangle through an output register.
module tfg_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	output logic            res_ready,
	input  tfg_pkg::res_t   res,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [135:0]    m_tdata,
	output logic [2:0]      m_tuser,
	output logic            m_tlast
);

	tfg_pkg::res_t   bank_q;
	logic [2:0]      k_q;
	logic            busy_q;
	logic            m_tvalid_q;
	logic [135:0]    m_tdata_q;
	logic [2:0]      m_tuser_q;
	logic            m_tlast_q;
	logic            load;
	tfg_pkg::vec3_t  vsel;

	assign res_ready = !busy_q;
	assign load = busy_q && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	always_comb begin
		case (k_q)
			tfg_pkg::K_EDGE12:   vsel = bank_q.e12;
			tfg_pkg::K_EDGE13:   vsel = bank_q.e13;
			tfg_pkg::K_NORMAL:   vsel = bank_q.nn;
			tfg_pkg::K_EY:       vsel = bank_q.ey;
			tfg_pkg::K_EX:       vsel = bank_q.ex;
			tfg_pkg::K_CENTROID: vsel = bank_q.ce;
			default:             vsel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= tfg_pkg::K_EDGE12;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_valid && !busy_q) begin
				busy_q <= 1'b1;
				k_q <= tfg_pkg::K_EDGE12;
			end else if (load) begin
				k_q <= k_q + 3'd1;
				if (k_q == tfg_pkg::K_CENTROID)
					busy_q <= 1'b0;
			end
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !busy_q)
			bank_q <= res;
		if (load) begin
			m_tdata_q <= {7'd0, bank_q.zedge, bank_q.zarea, bank_q.area,
				vsel[2], vsel[1], vsel[0]};
			m_tuser_q <= k_q;
			m_tlast_q <= (k_q == tfg_pkg::K_CENTROID);
		end
	end

endmodule

/* sv/triangle_frame_geometry.sv */
// Triangle frame geometry top level: front end, queue, back end and result sequencer.
// Each triangle gives six result transfers; the back end takes one triangle at a time, and its
// two 64-step square roots and two 26-step divider passes set the rate at which triangles go through.
// The front end and a two-entry queue keep taking triangles while the back end works.
// Reset: arst_n clears all control state asynchronously; no clearing pass is needed.
module triangle_frame_geometry (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
	input  logic [287:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// comp_x, comp_y, comp_z, tri_area, zero_area, zero_edge, zero pad
	output logic [135:0]  m_tdata,
	// vector_kind
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);

	logic            f_valid, f_ready;
	tfg_pkg::item_t  f_item;
	logic            q_valid, q_ready;
	tfg_pkg::item_t  q_item;
	logic            r_valid, r_ready;
	tfg_pkg::res_t   r_res;

	tfg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	tfg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	tfg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.res_valid (r_valid),
		.res_ready (r_ready),
		.res       (r_res)
	);

	tfg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (r_valid),
		.res_ready (r_ready),
		.res       (r_res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* tb/sv/triangle_frame_geometry_tb.sv */
// Testbench for the triangle frame geometry block: directed and random triangles, scoreboarded.
`timescale 1ns / 1ps

module triangle_frame_geometry_tb;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] cx, cy, cz;
		logic [30:0] area;
		logic zarea, zedge, last;
	} geo_res_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [287:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [135:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	geo_res_t expected_vecs[$];
	int mismatches = 0;
	int unexpected = 0;
	int results_seen = 0;
	int tris_sent = 0;
	int zero_area_tris = 0;
	int zero_edge_tris = 0;
	bit quiet_gaps = 0;
	int hold_off = 0;

	triangle_frame_geometry dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] root_floor(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= x) r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic [63:0] length3(input longint a, b, c);
		logic [127:0] s;
		s = {64'd0, mag(a)} * {64'd0, mag(a)} + {64'd0, mag(b)} * {64'd0, mag(b)}
			+ {64'd0, mag(c)} * {64'd0, mag(c)};
		return root_floor(s);
	endfunction

	// |n| * 2^24 / den truncated, signed back; den nonzero
	function automatic longint unit_comp(input longint n, input logic [63:0] den);
		logic [127:0] q;
		q = ({64'd0, mag(n)} << 24) / {64'd0, den};
		return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
		o[0] = a[1] * b[2] - b[1] * a[2];
		o[1] = -(a[0] * b[2] - b[0] * a[2]);
		o[2] = a[0] * b[1] - b[0] * a[1];
	endfunction

	task automatic predict_frame(input logic [287:0] d);
		longint v1[3], v2[3], v3[3], e12[3], e13[3], nc[3], nn[3], ey[3], exq[3], ex[3], ce[3];
		logic [63:0] len, elen, ar;
		bit za, ze;
		geo_res_t r;
		for (int c = 0; c < 3; c++) begin
			v1[c] = longint'($signed(d[32*c +: 32]));
			v2[c] = longint'($signed(d[32*(3+c) +: 32]));
			v3[c] = longint'($signed(d[32*(6+c) +: 32]));
			e12[c] = clamp32(v2[c] - v1[c]);
			e13[c] = clamp32(v3[c] - v1[c]);
			ce[c] = clamp32((v1[c] + v2[c] + v3[c]) / 3);
		end
		cross3(e12, e13, nc);
		len = length3(nc[0], nc[1], nc[2]);
		za = (len == 0);
		ar = len >> 25;
		if (ar > 64'h7FFF_FFFF) ar = 64'h7FFF_FFFF;
		for (int c = 0; c < 3; c++) nn[c] = za ? nc[c] : unit_comp(nc[c], len);
		elen = length3(e13[0], e13[1], e13[2]);
		ze = (elen == 0);
		if (ze) elen = tfg_pkg::ONE_Q24;
		for (int c = 0; c < 3; c++) ey[c] = unit_comp(e13[c], elen);
		cross3(ey, nn, exq);
		for (int c = 0; c < 3; c++) begin
			ex[c] = clamp32(exq[c] < 0 ? -longint'(mag(exq[c]) >> 24)
				: longint'(mag(exq[c]) >> 24));
			nn[c] = clamp32(nn[c]);
		end
		if (za) zero_area_tris++;
		if (ze) zero_edge_tris++;
		for (int k = 0; k < 6; k++) begin
			longint vv[3];
			case (k)
				0: vv = e12;
				1: vv = e13;
				2: vv = nn;
				3: vv = ey;
				4: vv = ex;
				default: vv = ce;
			endcase
			r.kind = 3'(k);
			r.cx = vv[0][31:0];
			r.cy = vv[1][31:0];
			r.cz = vv[2][31:0];
			r.area = ar[30:0];
			r.zarea = za;
			r.zedge = ze;
			r.last = (k == 5);
			expected_vecs.push_back(r);
		end
	endtask

	// tvalid stays up after a transfer so the next one can follow at once
	task automatic send_triangle(input logic [287:0] d);
		if (!quiet_gaps) begin
			while ($urandom_range(99) < 9) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_frame(d);
		tris_sent++;
		@(negedge clk);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [287:0] tri_of(input logic [31:0] p[9]);
		logic [287:0] d;
		for (int i = 0; i < 9; i++) d[32*i +: 32] = p[i];
		return d;
	endfunction

	// receiver side: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else
				m_tready <= quiet_gaps ? 1'b1 : ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			geo_res_t g, e;
			g.kind = m_tuser;
			g.cx = m_tdata[31:0];
			g.cy = m_tdata[63:32];
			g.cz = m_tdata[95:64];
			g.area = m_tdata[126:96];
			g.zarea = m_tdata[127];
			g.zedge = m_tdata[128];
			g.last = m_tlast;
			results_seen++;
			if (expected_vecs.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kind %0d", g.kind);
			end else begin
				e = expected_vecs.pop_front();
				if (g !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp k%0d %h %h %h a%h z%b%b l%b got k%0d %h %h %h a%h z%b%b l%b",
							e.kind, e.cx, e.cy, e.cz, e.area, e.zarea, e.zedge, e.last,
							g.kind, g.cx, g.cy, g.cz, g.area, g.zarea, g.zedge, g.last);
				end
			end
		end
	end

	task automatic test_directed();
		logic [31:0] p[9];
		// right triangle in the xy plane
		p = '{32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0};
		send_triangle(tri_of(p));
		// all vertices equal: zero area and zero edge
		p = '{default: 32'h1234_5678};
		send_triangle(tri_of(p));
		// v3 == v1 but v2 apart: zero edge13
		p = '{32'h1, 32'h2, 32'h3, 32'h0200_0000, 32'h5, 32'h6, 32'h1, 32'h2, 32'h3};
		send_triangle(tri_of(p));
		// collinear: zero area, nonzero edge
		p = '{32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 32'h0,
			32'h0200_0000, 32'h0200_0000, 32'h0};
		send_triangle(tri_of(p));
		// edge overflow both ways
		p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF};
		send_triangle(tri_of(p));
		p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_triangle(tri_of(p));
		p = '{default: 32'h8000_0000};
		send_triangle(tri_of(p));
		p = '{default: 32'h7FFF_FFFF};
		send_triangle(tri_of(p));
		p = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1,
			32'hFFFF_FFFF};
		send_triangle(tri_of(p));
		// huge triangle for area saturation
		p = '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_triangle(tri_of(p));
		end_burst();
	endtask

	task automatic test_random(input int n);
		logic [31:0] p[9];
		for (int t = 0; t < n; t++) begin
			for (int i = 0; i < 9; i++) begin
				case ($urandom_range(9))
					0: p[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					1, 2, 3: p[i] = $urandom;
					default: p[i] = 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
				endcase
			end
			// occasional degenerate shapes
			if ($urandom_range(15) == 0) for (int c = 0; c < 3; c++) p[6+c] = p[c];
			if ($urandom_range(15) == 0) for (int c = 0; c < 3; c++) p[3+c] = p[6+c];
			send_triangle(tri_of(p));
		end
		end_burst();
	endtask

	task automatic test_backpressure();
		hold_off = 2000;
		test_random(6);
		wait (expected_vecs.size() == 0);
	endtask

	task automatic test_no_gaps();
		quiet_gaps = 1;
		test_random(20);
		wait (expected_vecs.size() == 0);
		quiet_gaps = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_no_gaps();
		test_random(124);
		wait (expected_vecs.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d triangles, %0d results; %0d zero-area, %0d zero-edge",
			tris_sent, results_seen, zero_area_tris, zero_edge_tris);
		$display("%0d mismatches, %0d unexpected transfers", mismatches, unexpected);
		if (mismatches == 0 && expected_vecs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/tfg_pkg.sv
sv/tfg_front.sv
sv/tfg_queue.sv
sv/tfg_back.sv
sv/tfg_emit.sv
sv/triangle_frame_geometry.sv
tb/sv/triangle_frame_geometry_tb.sv
